[hw/rtl/double_ended_queue_macros.svh]
// Assertion helpers for the deque RTL.
`ifndef DOUBLE_ENDED_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_MACROS_SVH

// expr must never be true on an active clock edge
`define DQ_ASSERT_NEVER(lbl, expr) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(expr)) \
      else $error("deque check failed: never");

// ante on this edge implies cons on the same edge
`define DQ_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("deque check failed: same cycle");

// ante on this edge implies cons on the next edge
`define DQ_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("deque check failed: next cycle");

`endif

[hw/rtl/dq_pkg.sv]
package dq_pkg;

   localparam int DEPTH_DEFAULT      = 16;
   localparam int DATA_WIDTH_DEFAULT = 32;
   localparam int CNT_W              = 5;

   typedef enum logic [2:0] {
      ACT_PUSH_FRONT = 3'd0,
      ACT_PUSH_BACK  = 3'd1,
      ACT_POP_FRONT  = 3'd2,
      ACT_POP_BACK   = 3'd3,
      ACT_PEEK_FRONT = 3'd4,
      ACT_PEEK_BACK  = 3'd5
   } action_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      logic [2:0]         action;
      logic signed [31:0] push_value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] read_value;
      logic [1:0]         status;
      logic [CNT_W-1:0]   entry_count;
      logic               is_empty;
   } rsp_type;

   // decoded action handed from the pointer unit to the response stage
   typedef struct packed {
      logic             we;
      logic             re;
      status_type       status;
      logic [CNT_W-1:0] count;
      logic             empty;
   } op_type;

endpackage

[hw/rtl/dq_ring_mem.sv]
module dq_ring_mem #(
   parameter int DEPTH      = dq_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = dq_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                         clock,
   input  logic                         we,
   input  logic                         re,
   input  logic [$clog2(DEPTH)-1:0]     addr,
   input  logic [DATA_WIDTH-1:0]        wdata,
   output logic [DATA_WIDTH-1:0]        rdata
);

   logic [DATA_WIDTH-1:0] mem [DEPTH];
   logic [DATA_WIDTH-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rd_ff <= mem[addr];
      end
   end

   assign rdata = rd_ff;

endmodule

[hw/rtl/dq_ptr.sv]
module dq_ptr #(
   parameter int DEPTH = dq_pkg::DEPTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  logic [2:0]               action,
   output logic [$clog2(DEPTH)-1:0] slot,
   output dq_pkg::op_type           op
);

   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = CW + 1;
   localparam logic [IW-1:0] LAST     = IW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
   localparam logic [SW-1:0] WRAP     = SW'(DEPTH);

   logic [IW-1:0] front_ff, front_in;
   logic [CW-1:0] count_ff, count_in;
   logic [IW-1:0] front_dec, front_inc, tail, back;
   logic [SW-1:0] tail_sum;
   logic          full, empty;

   assign full      = (count_ff == FULL_CNT);
   assign empty     = (count_ff == '0);
   assign front_dec = (front_ff == '0) ? LAST : front_ff - IW'(1);
   assign front_inc = (front_ff == LAST) ? '0 : front_ff + IW'(1);
   assign tail_sum  = SW'(front_ff) + SW'(count_ff);
   assign tail      = (tail_sum >= WRAP) ? IW'(tail_sum - WRAP) : IW'(tail_sum);
   assign back      = (tail == '0) ? LAST : tail - IW'(1);

   always_comb begin
      front_in  = front_ff;
      count_in  = count_ff;
      slot      = front_ff;
      op.we     = 1'b0;
      op.re     = 1'b0;
      op.status = dq_pkg::ST_OK;
      case (action)
         dq_pkg::ACT_PUSH_FRONT, dq_pkg::ACT_PUSH_BACK: begin
            if (full) begin
               op.status = dq_pkg::ST_FULL;
            end else begin
               op.we    = 1'b1;
               count_in = count_ff + CW'(1);
               if (action == dq_pkg::ACT_PUSH_FRONT) begin
                  slot     = front_dec;
                  front_in = front_dec;
               end else begin
                  slot = tail;
               end
            end
         end
         dq_pkg::ACT_POP_FRONT, dq_pkg::ACT_POP_BACK,
         dq_pkg::ACT_PEEK_FRONT, dq_pkg::ACT_PEEK_BACK: begin
            if (empty) begin
               op.status = dq_pkg::ST_EMPTY;
            end else begin
               op.re = 1'b1;
               if (action == dq_pkg::ACT_POP_FRONT ||
                   action == dq_pkg::ACT_PEEK_FRONT) begin
                  slot = front_ff;
               end else begin
                  slot = back;
               end
               if (action == dq_pkg::ACT_POP_FRONT) begin
                  front_in = front_inc;
               end
               if (action == dq_pkg::ACT_POP_FRONT ||
                   action == dq_pkg::ACT_POP_BACK) begin
                  count_in = count_ff - CW'(1);
               end
            end
         end
         default: begin
         end
      endcase
      op.count = dq_pkg::CNT_W'(count_in);
      op.empty = (count_in == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         count_ff <= '0;
      end else if (en) begin
         front_ff <= front_in;
         count_ff <= count_in;
      end
   end

endmodule

[hw/rtl/double_ended_queue.sv]
// Channel   Ports                             Direction  Word
// request   req_valid, req_stall, req_data    in         dq_pkg::req_type
// response  rsp_valid, rsp_stall, rsp_data    out        dq_pkg::rsp_type
//
// One action is taken per cycle while req_stall is low; its response passes
// through the ring memory read register and then the output register.
// Pointers update on the accept edge, so a read in the next cycle sees the write.
// Synchronous reset empties the queue at once; the ring memory is not cleared.
// A stalled response holds the read stage, and req_stall rises with it.
`include "double_ended_queue_macros.svh"

module double_ended_queue #(
   parameter int DEPTH      = dq_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = dq_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  dq_pkg::req_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output dq_pkg::rsp_type rsp_data
);

   localparam int IW = $clog2(DEPTH);

   logic                   accept, advance;
   logic [IW-1:0]          slot;
   dq_pkg::op_type         op;
   logic [DATA_WIDTH-1:0]  rdata;
   logic signed [DATA_WIDTH-1:0] rd_s;
   logic signed [31:0]     read_ext;
   logic                   rsp_err_empty;

   logic                   s1_valid_ff, s1_valid_in;
   dq_pkg::op_type         s1_op_ff;
   logic                   out_valid_ff, out_valid_in;
   dq_pkg::rsp_type        out_ff, out_in;

   assign advance   = s1_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && out_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   dq_ptr #(.DEPTH(DEPTH)) u_ptr (
      .clock  (clock),
      .reset  (reset),
      .en     (accept),
      .action (req_data.action),
      .slot   (slot),
      .op     (op)
   );

   dq_ring_mem #(.DEPTH(DEPTH), .DATA_WIDTH(DATA_WIDTH)) u_mem (
      .clock (clock),
      .we    (accept && op.we),
      .re    (accept && op.re),
      .addr  (slot),
      .wdata (DATA_WIDTH'(req_data.push_value)),
      .rdata (rdata)
   );

   assign rd_s     = rdata;
   assign read_ext = 32'(rd_s);

   assign s1_valid_in  = accept || (s1_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   always_comb begin
      out_in             = out_ff;
      out_in.read_value  = s1_op_ff.re ? read_ext : '0;
      out_in.status      = s1_op_ff.status;
      out_in.entry_count = s1_op_ff.count;
      out_in.is_empty    = s1_op_ff.empty;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_op_ff <= op;
      end
      if (advance) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   assign rsp_err_empty = rsp_valid && (rsp_data.status == dq_pkg::ST_EMPTY);

   `DQ_ASSERT_NEVER(a_no_overwrite_s1, accept && s1_valid_ff && !advance)
   `DQ_ASSERT_NEVER(a_one_mem_access, op.we && op.re)
   `DQ_ASSERT_NEXT(a_advance_shows, advance, rsp_valid)
   `DQ_ASSERT_NOW(a_empty_err, rsp_err_empty, rsp_data.is_empty && rsp_data.read_value == '0)

endmodule
